FILE: src/cel_pkg.sv
// Package: types and constants of the cross-entropy loss unit.
package cel_pkg;
   localparam int PROB_FRAC_BITS = 16;
   localparam int LOG_FRAC = 24;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

   typedef enum logic {
      KIND_FORWARD = 1'b0,
      KIND_BACKWARD = 1'b1
   } kind_type;

   typedef struct packed {
      logic        kind;
      logic [16:0] probability;
      logic [16:0] target;
      logic signed [31:0] row_gradient;
      logic        last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic        is_gradient;
      logic        saturated;
      logic        zero_probability;
   } rsp_type;

   localparam int QUEUE_DEPTH = 2;
endpackage

FILE: src/cel_queue.sv
// Two-entry queue between the front and back parts.
module cel_queue import cel_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output req_type out_data
);
   req_type mem_ff [QUEUE_DEPTH];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_stall  = (cnt_ff == 2'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_comb begin
      rd_in  = pop ? ~rd_ff : rd_ff;
      wr_in  = push ? ~wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

FILE: src/cel_back.sv
// Back part: iterative log and divide, row accumulation and result register.
module cel_back import cel_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  req_type in_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_LOG, S_LMUL, S_LRND, S_TMUL, S_ACC, S_GMUL, S_DIV, S_GFIN, S_OUT
   } state_type;

   state_type state_ff;
   req_type item_ff;
   logic [31:0] m_ff;
   logic [23:0] frac_ff;
   logic [5:0]  cnt_ff;
   logic [4:0]  k_ff;
   logic        neg_ff;
   logic [63:0] prod_ff;
   logic [31:0] mag_ff;
   logic [48:0] rem_ff;
   logic [49:0] quo_ff;
   logic signed [31:0] sum_ff;
   logic        rsat_ff, rzp_ff;
   rsp_type     out_ff;

   logic [4:0] k_c;
   logic [63:0] sq;
   logic [48:0] num_c;
   logic [31:0] gmag;
   logic signed [33:0] nsum;

   assign in_stall  = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = out_ff;
   assign gmag = item_ff.row_gradient[31] ? 32'(-item_ff.row_gradient)
                                          : 32'(item_ff.row_gradient);

   always_comb begin
      k_c = 5'd0;
      for (int i = 1; i <= 16; i++) if (in_data.probability[i]) k_c = 5'(i);
      sq = 64'(m_ff) * 64'(m_ff);
      num_c = 49'(item_ff.target) * 49'(gmag);
      nsum = 34'(sum_ff) + (neg_ff ? -34'(mag_ff) : 34'(mag_ff));
   end

   logic [49:0] div_den;
   logic [49:0] div_rem2;
   assign div_den  = 50'(item_ff.probability);
   assign div_rem2 = {rem_ff, quo_ff[49]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sum_ff   <= '0;
         rsat_ff  <= 1'b0;
         rzp_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (in_valid) begin
               item_ff <= in_data;
               if (in_data.kind == KIND_FORWARD) begin
                  if (in_data.probability == 17'd0) begin
                     rzp_ff   <= 1'b1;
                     mag_ff   <= '0;
                     neg_ff   <= 1'b0;
                     state_ff <= S_ACC;
                  end else begin
                     k_ff     <= k_c;
                     m_ff     <= 32'(64'(in_data.probability) << (30 - int'(k_c)));
                     frac_ff  <= '0;
                     cnt_ff   <= 6'(LOG_FRAC);
                     state_ff <= S_LOG;
                  end
               end else begin
                  state_ff <= S_GMUL;
               end
            end
            S_LOG: begin
               if (sq[61]) begin
                  m_ff    <= 32'(sq >> 31);
                  frac_ff <= {frac_ff[22:0], 1'b1};
               end else begin
                  m_ff    <= 32'(sq >> 30);
                  frac_ff <= {frac_ff[22:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) state_ff <= S_LMUL;
            end
            S_LMUL: begin
               // l2 = (k-16)*2^24 + frac; n = -l2
               if (k_ff == 5'd16) begin
                  neg_ff  <= (frac_ff != 24'd0);
                  mag_ff  <= {8'd0, frac_ff};
               end else begin
                  neg_ff  <= 1'b0;
                  mag_ff  <= 32'(((41'd16 - 41'(k_ff)) << 24) - 41'(frac_ff));
               end
               state_ff <= S_LRND;
            end
            S_LRND: begin
               prod_ff  <= 64'(mag_ff) * 64'(LN2_Q32);
               state_ff <= S_TMUL;
            end
            S_TMUL: begin
               // r = round(prod / 2^40), then term = round(r*t / 2^16)
               mag_ff   <= 32'(((64'((prod_ff + 64'(1) * (64'd1 << 39)) >> 40))
                            * 64'(item_ff.target) + 64'd32768) >> 16);
               state_ff <= S_ACC;
            end
            S_ACC: begin
               logic signed [31:0] ns;
               logic               ovf;
               ns = sum_ff; ovf = 1'b0;
               if (item_ff.probability != 17'd0) begin
                  if (nsum > 34'sh7fffffff) begin ns = VAL_MAX; ovf = 1'b1; end
                  else if (nsum < -34'sh80000000) begin ns = VAL_MIN; ovf = 1'b1; end
                  else ns = 32'(nsum);
               end
               if (item_ff.last) begin
                  out_ff.is_gradient <= 1'b0;
                  out_ff.zero_probability <= rzp_ff;
                  out_ff.value <= rzp_ff ? VAL_MAX : ns;
                  out_ff.saturated <= rzp_ff | rsat_ff | ovf;
                  sum_ff  <= '0;
                  rsat_ff <= 1'b0;
                  rzp_ff  <= 1'b0;
                  state_ff <= S_OUT;
               end else begin
                  sum_ff  <= ns;
                  if (ovf) rsat_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_GMUL: begin
               // dividend 2*num + p, divisor 2*p
               quo_ff   <= 50'({num_c, 1'b0} + 50'(item_ff.probability));
               rem_ff   <= '0;
               cnt_ff   <= 6'd50;
               state_ff <= (item_ff.probability == 17'd0) ? S_GFIN : S_DIV;
               prod_ff  <= 64'(num_c);
            end
            S_DIV: begin
               if (div_rem2 >= {div_den[48:0], 1'b0}) begin
                  rem_ff <= 49'(div_rem2 - {div_den[48:0], 1'b0});
                  quo_ff <= {quo_ff[48:0], 1'b1};
               end else begin
                  rem_ff <= 49'(div_rem2);
                  quo_ff <= {quo_ff[48:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) state_ff <= S_GFIN;
            end
            S_GFIN: begin
               out_ff.is_gradient <= 1'b1;
               if (item_ff.probability == 17'd0) begin
                  out_ff.zero_probability <= 1'b1;
                  if (prod_ff == 64'd0) begin
                     out_ff.value <= '0; out_ff.saturated <= 1'b0;
                  end else begin
                     out_ff.value <= item_ff.row_gradient[31] ? VAL_MAX : VAL_MIN;
                     out_ff.saturated <= 1'b1;
                  end
               end else begin
                  out_ff.zero_probability <= 1'b0;
                  if (!item_ff.row_gradient[31]) begin
                     if (quo_ff > 50'd2147483648) begin
                        out_ff.value <= VAL_MIN; out_ff.saturated <= 1'b1;
                     end else begin
                        out_ff.value <= 32'(-quo_ff); out_ff.saturated <= 1'b0;
                     end
                  end else begin
                     if (quo_ff > 50'd2147483647) begin
                        out_ff.value <= VAL_MAX; out_ff.saturated <= 1'b1;
                     end else begin
                        out_ff.value <= 32'(quo_ff); out_ff.saturated <= 1'b0;
                     end
                  end
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: src/cross_entropy_loss_unit.sv
// Top level of the cross-entropy loss unit.
// Input channel req_: one element a transfer, kind selects forward loss or
// backward gradient. Result channel rsp_: a row loss on each forward item
// marked last, an element gradient on each backward item; other forward
// items give no result.
// The front part is a two-entry queue that takes items while the back part
// works; an item is written into the queue before the back part sees it.
// The back part takes one item at a time: a forward item passes through 24
// squaring steps of the log unit, three of scaling and rounding, the
// accumulate and the take, and the output when it closes a row; a backward
// item a 50-step restoring divider plus setup, finish and output. A zero
// probability skips the iteration. Throughput is set by that shared iterative back end.
// The result is held in a register until taken; while rsp_stall is high the
// back end waits and the queue fills, then req_stall rises.
// Synchronous reset clears the queue, the row sum and the row flags.
module cross_entropy_loss_unit import cel_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   logic q_valid, q_stall;
   req_type q_data;

   cel_queue u_queue (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall), .in_data(req_data),
      .out_valid(q_valid), .out_stall(q_stall), .out_data(q_data)
   );

   cel_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_stall(q_stall), .in_data(q_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
